// File: rtl/mdm_pkg.sv
`default_nettype none

package mdm_pkg;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    REG_SETUP   = 3'd0,
    REG_CONTROL = 3'd1,
    REG_WDATA   = 3'd2,
    REG_RDATA   = 3'd3,
    REG_STATUS  = 3'd4,
    REG_PENDING = 3'd5,
    REG_ENABLE  = 3'd6,
    REG_CLEAR   = 3'd7
  } reg_idx_t;

  localparam logic [1:0] OP_READ      = 2'b10;
  localparam logic [1:0] TA_WRITE     = 2'b10;
  localparam int         INITIATE_BIT = 11;
  localparam int         EN_BIT       = 6;
  // MDIO is released for the turnaround and data bits of a read frame
  localparam logic [5:0] RD_RELEASE   = 6'd18;
  localparam logic [5:0] DATA_BITS    = 6'd16;

  typedef struct packed {
    logic [31:0] read_data;
    logic        mdc_level;
    logic        mdio_out;
    logic        mdio_drive;
    logic        irq_line;
    logic        ready_flag;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/mdm_in_if.sv
`default_nettype none

interface mdm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [2:0]  reg_index;
  logic [31:0] write_data;
  logic        mdio_in;

  modport source (output valid, func, reg_index, write_data, mdio_in, input ready);
  modport sink   (input valid, func, reg_index, write_data, mdio_in, output ready);
endinterface

`default_nettype wire

// File: rtl/mdm_out_if.sv
`default_nettype none

interface mdm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        mdc_level;
  logic        mdio_out;
  logic        mdio_drive;
  logic        irq_line;
  logic        ready_flag;

  modport source (output valid, read_data, mdc_level, mdio_out, mdio_drive, irq_line,
                  ready_flag, input ready);
  modport sink   (input valid, read_data, mdc_level, mdio_out, mdio_drive, irq_line,
                  ready_flag, output ready);
endinterface

`default_nettype wire

// File: rtl/mdio_master_registers_core.sv
// channel   direction  beat contents
// in_bus    sink       func, reg_index, write_data, mdio_in
// out_bus   source     read_data, mdc_level, mdio_out, mdio_drive, irq_line, ready_flag
// cfg (APB) slave      MDC divider at 0x0, interface enable at 0x4
//
// One input beat per cycle while in_bus.ready is high; each gives one result beat.
// The result register plus a one-entry skid buffer keep in_bus.ready high
// until two results are waiting on a stalled out_bus.
// rst_n is synchronous: idle bus, MDC low, registers zero bar the result data.
`default_nettype none

module mdio_master_registers_core #(
  parameter int PREAMBLE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  mdm_in_if.sink           in_bus,
  mdm_out_if.source        out_bus,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [63:0] PRE_MASK  = ((64'd1 << PREAMBLE_BITS) - 64'd1) << 32;
  localparam logic [6:0]  FRAME_LEN = 7'(PREAMBLE_BITS + 32);

  logic [5:0]  div_r,   div_nxt;
  logic        en_r,    en_nxt;
  logic [4:0]  pa_r,    pa_nxt;
  logic [4:0]  ra_r,    ra_nxt;
  logic [1:0]  op_r,    op_nxt;
  logic [15:0] ww_r,    ww_nxt;
  logic [15:0] rw_r,    rw_nxt;
  logic [63:0] frame_r, frame_nxt;
  logic [6:0]  bit_r,   bit_nxt;
  logic [6:0]  tick_r,  tick_nxt;
  logic        mdc_r,   mdc_nxt;
  logic        busy_r,  busy_nxt;
  logic        stat_r,  stat_nxt;
  logic        ien_r,   ien_nxt;

  mdm_pkg::res_t out_r, skid_r, res;
  logic          out_valid_r, skid_valid_r;

  logic          acc, take, cfg_wr;
  mdm_pkg::func_t    func;
  mdm_pkg::reg_idx_t ridx;
  logic [31:0]   wdat;
  logic          rdy_cur;
  logic [6:0]    bc_m1, bcn_m1, tick_inc;
  logic [5:0]    cur_idx, nxt_idx;
  logic          drv;
  logic [31:0]   rd;

  assign acc    = in_bus.valid && in_bus.ready;
  assign take   = out_valid_r && out_bus.ready;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign func   = mdm_pkg::func_t'(in_bus.func);
  assign ridx   = mdm_pkg::reg_idx_t'(in_bus.reg_index);
  assign wdat   = in_bus.write_data;

  assign rdy_cur  = en_r && (div_r != 6'd0) && !busy_r;
  assign bc_m1    = bit_r - 7'd1;
  assign cur_idx  = bc_m1[5:0];
  assign tick_inc = tick_r + 7'd1;

  always_comb begin
    unique case (ridx)
      mdm_pkg::REG_SETUP:   rd = {25'd0, en_r, div_r};
      mdm_pkg::REG_CONTROL: rd = {3'd0, pa_r, 3'd0, ra_r, 8'd0, rdy_cur, 7'd0};
      mdm_pkg::REG_WDATA:   rd = {16'd0, ww_r};
      mdm_pkg::REG_RDATA:   rd = {15'd0, rdy_cur, rw_r};
      mdm_pkg::REG_STATUS:  rd = {31'd0, stat_r};
      mdm_pkg::REG_PENDING: rd = {31'd0, stat_r & ien_r};
      mdm_pkg::REG_ENABLE:  rd = {31'd0, ien_r};
      mdm_pkg::REG_CLEAR:   rd = 32'd0;
    endcase
  end

  always_comb begin
    div_nxt   = div_r;
    en_nxt    = en_r;
    pa_nxt    = pa_r;
    ra_nxt    = ra_r;
    op_nxt    = op_r;
    ww_nxt    = ww_r;
    rw_nxt    = rw_r;
    frame_nxt = frame_r;
    bit_nxt   = bit_r;
    tick_nxt  = tick_r;
    mdc_nxt   = mdc_r;
    busy_nxt  = busy_r;
    stat_nxt  = stat_r;
    ien_nxt   = ien_r;

    if (acc) begin
      case (func)
        mdm_pkg::FUNC_WRITE: begin
          unique case (ridx)
            mdm_pkg::REG_SETUP: begin
              div_nxt = wdat[5:0];
              en_nxt  = wdat[mdm_pkg::EN_BIT];
            end
            mdm_pkg::REG_CONTROL: begin
              if (!busy_r) begin
                op_nxt = wdat[15:14];
                ra_nxt = wdat[20:16];
                pa_nxt = wdat[28:24];
                if (wdat[mdm_pkg::INITIATE_BIT] && rdy_cur) begin
                  frame_nxt = PRE_MASK | {33'd0, 1'b1, wdat[15:14], wdat[28:24],
                    wdat[20:16],
                    (wdat[15:14] == mdm_pkg::OP_READ) ? 2'b00 : mdm_pkg::TA_WRITE,
                    (wdat[15:14] == mdm_pkg::OP_READ) ? 16'd0 : ww_r};
                  bit_nxt  = FRAME_LEN;
                  tick_nxt = 7'd0;
                  mdc_nxt  = 1'b0;
                  busy_nxt = 1'b1;
                end
              end
            end
            mdm_pkg::REG_WDATA:  ww_nxt   = wdat[15:0];
            mdm_pkg::REG_STATUS: stat_nxt = wdat[0];
            mdm_pkg::REG_ENABLE: ien_nxt  = wdat[0];
            mdm_pkg::REG_CLEAR:  stat_nxt = stat_r & ~wdat[0];
            default: ;
          endcase
        end
        mdm_pkg::FUNC_TICK: begin
          if (busy_r) begin
            if (!en_r || div_r == 6'd0) begin
              // abort: MDC low, MDIO released, no status
              busy_nxt = 1'b0;
              mdc_nxt  = 1'b0;
              tick_nxt = 7'd0;
              bit_nxt  = 7'd0;
            end else begin
              tick_nxt = tick_inc;
              if (!mdc_r) begin
                if (tick_inc >= {1'b0, div_r} + 7'd1) begin
                  mdc_nxt  = 1'b1;
                  tick_nxt = 7'd0;
                  if (op_r == mdm_pkg::OP_READ && cur_idx < mdm_pkg::DATA_BITS)
                    frame_nxt[cur_idx] = in_bus.mdio_in;
                end
              end else if (tick_inc >= {1'b0, div_r}) begin
                mdc_nxt  = 1'b0;
                tick_nxt = 7'd0;
                bit_nxt  = bc_m1;
                if (bc_m1 == 7'd0) begin
                  busy_nxt = 1'b0;
                  stat_nxt = 1'b1;
                  if (op_r == mdm_pkg::OP_READ) rw_nxt = frame_r[15:0];
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign bcn_m1  = bit_nxt - 7'd1;
  assign nxt_idx = bcn_m1[5:0];
  assign drv = busy_nxt && (bit_nxt != 7'd0) &&
               !(op_nxt == mdm_pkg::OP_READ && nxt_idx < mdm_pkg::RD_RELEASE);

  always_comb begin
    res.read_data  = (func == mdm_pkg::FUNC_READ) ? rd : 32'd0;
    res.mdc_level  = mdc_nxt;
    res.mdio_drive = drv;
    res.mdio_out   = drv & frame_nxt[nxt_idx];
    res.irq_line   = stat_nxt & ien_nxt;
    res.ready_flag = en_nxt && (div_nxt != 6'd0) && !busy_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r  <= 6'd0;
      en_r   <= 1'b0;
      pa_r   <= 5'd0;
      ra_r   <= 5'd0;
      op_r   <= 2'd0;
      ww_r   <= 16'd0;
      rw_r   <= 16'd0;
      frame_r <= 64'd0;
      bit_r  <= 7'd0;
      tick_r <= 7'd0;
      mdc_r  <= 1'b0;
      busy_r <= 1'b0;
      stat_r <= 1'b0;
      ien_r  <= 1'b0;
    end else begin
      div_r  <= div_nxt;
      en_r   <= en_nxt;
      pa_r   <= pa_nxt;
      ra_r   <= ra_nxt;
      op_r   <= op_nxt;
      ww_r   <= ww_nxt;
      rw_r   <= rw_nxt;
      frame_r <= frame_nxt;
      bit_r  <= bit_nxt;
      tick_r <= tick_nxt;
      mdc_r  <= mdc_nxt;
      busy_r <= busy_nxt;
      stat_r <= stat_nxt;
      ien_r  <= ien_nxt;
      if (cfg_wr) begin
        if (!paddr[2]) div_r <= pwdata[5:0];
        else           en_r  <= pwdata[0];
      end
    end
  end

  // result register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (take || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= acc;
      end
    end else if (acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take || !out_valid_r) begin
      if (skid_valid_r) out_r <= skid_r;
      else if (acc)     out_r <= res;
    end else if (acc) begin
      skid_r <= res;
    end
  end

  assign in_bus.ready       = !skid_valid_r;
  assign out_bus.valid      = out_valid_r;
  assign out_bus.read_data  = out_r.read_data;
  assign out_bus.mdc_level  = out_r.mdc_level;
  assign out_bus.mdio_out   = out_r.mdio_out;
  assign out_bus.mdio_drive = out_r.mdio_drive;
  assign out_bus.irq_line   = out_r.irq_line;
  assign out_bus.ready_flag = out_r.ready_flag;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {31'd0, en_r} : {26'd0, div_r};

`ifndef ASSERT_OFF
  a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r == (bit_r != 7'd0))
    else $error("busy flag and bit count disagree");

  a_idle_mdc: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (!mdc_r && tick_r == 7'd0))
    else $error("MDC not parked low while idle");

  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with empty result register");

  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy_r && busy_nxt) |=> (bit_r == FRAME_LEN && !mdc_r))
    else $error("frame started with wrong bit count");
`endif

endmodule

`default_nettype wire

// File: verif/tb_mdio_master_registers_core.sv
`timescale 1ns / 100ps

module tb_mdio_master_registers_core;

  localparam logic [2:0] CFG_DIVIDE_ADDR = 3'd0;
  localparam logic [2:0] CFG_ENABLE_ADDR = 3'd4;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASE_BEATS = 60;

  typedef struct packed {
    mdm_pkg::func_t    f;
    mdm_pkg::reg_idx_t ri;
    logic [31:0]       wd;
    logic              pin;
    logic              typed;
    logic [31:0]       rd;
  } table_row_t;

  typedef struct {
    mdm_pkg::res_t pins;
    logic          typed;
    logic [31:0]   typed_rd;
  } pin_expect_t;

  // typed read values only where they follow directly from reset or a prior write
  localparam int N_ROWS = 27;
  localparam table_row_t DIRECTED_ROWS [N_ROWS] = '{
    '{mdm_pkg::FUNC_READ,  mdm_pkg::REG_SETUP,   32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000},
    '{mdm_pkg::FUNC_READ,  mdm_pkg::REG_CONTROL, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000},
    '{mdm_pkg::FUNC_WRITE, mdm_pkg::REG_SETUP,   32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0000_0000},
    '{mdm_pkg::FUNC_READ,  mdm_pkg::REG_SETUP,   32'h0000_0000, 1'b0, 1'b1, 32'h0000_007F},
    '{mdm_pkg::FUNC_WRITE, mdm_pkg::REG_ENABLE,  32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0000_0000},
    '{mdm_pkg::FUNC_READ,  mdm_pkg::REG_ENABLE,  32'h0000_0000, 1'b0, 1'b1, 32'h0000_0001},
    '{mdm_pkg::FUNC_WRITE, mdm_pkg::REG_STATUS,  32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
    '{mdm_pkg::FUNC_READ,  mdm_pkg::REG_STATUS,  32'h0000_0000, 1'b0, 1'b1, 32'h0000_0001},
    '{mdm_pkg::FUNC_READ,  mdm_pkg::REG_PENDING, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0001},
    '{mdm_pkg::FUNC_WRITE, mdm_pkg::REG_CLEAR,   32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0000_0000},
    '{mdm_pkg::FUNC_READ,  mdm_pkg::REG_STATUS,  32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000},
    '{mdm_pkg::FUNC_WRITE, mdm_pkg::REG_WDATA,   32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0000_0000},
    '{mdm_pkg::FUNC_READ,  mdm_pkg::REG_WDATA,   32'h0000_0000, 1'b0, 1'b1, 32'h0000_FFFF},
    '{mdm_pkg::FUNC_WRITE, mdm_pkg::REG_CONTROL, 32'h1F1F_C000, 1'b0, 1'b0, 32'h0000_0000},
    '{mdm_pkg::FUNC_READ,  mdm_pkg::REG_CONTROL, 32'h0000_0000, 1'b0, 1'b1, 32'h1F1F_0080},
    // initiate while disabled only latches the addresses and opcode
    '{mdm_pkg::FUNC_WRITE, mdm_pkg::REG_SETUP,   32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    '{mdm_pkg::FUNC_WRITE, mdm_pkg::REG_CONTROL, 32'h0A05_8800, 1'b0, 1'b0, 32'h0000_0000},
    '{mdm_pkg::FUNC_READ,  mdm_pkg::REG_CONTROL, 32'h0000_0000, 1'b0, 1'b1, 32'h0A05_0000},
    '{mdm_pkg::FUNC_WRITE, mdm_pkg::REG_SETUP,   32'h0000_0041, 1'b0, 1'b0, 32'h0000_0000},
    '{mdm_pkg::FUNC_WRITE, mdm_pkg::REG_CONTROL, 32'h0A05_8800, 1'b0, 1'b0, 32'h0000_0000},
    '{mdm_pkg::FUNC_READ,  mdm_pkg::REG_RDATA,   32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000},
    '{mdm_pkg::FUNC_TICK,  mdm_pkg::REG_SETUP,   32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    // control write during a frame is dropped
    '{mdm_pkg::FUNC_WRITE, mdm_pkg::REG_CONTROL, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0000_0000},
    '{mdm_pkg::FUNC_NOP,   mdm_pkg::REG_CLEAR,   32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
    // disable mid-frame, next tick aborts
    '{mdm_pkg::FUNC_WRITE, mdm_pkg::REG_SETUP,   32'h0000_0001, 1'b0, 1'b0, 32'h0000_0000},
    '{mdm_pkg::FUNC_TICK,  mdm_pkg::REG_SETUP,   32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    '{mdm_pkg::FUNC_READ,  mdm_pkg::REG_CONTROL, 32'h0000_0000, 1'b0, 1'b1, 32'h0A05_0000}
  };

  localparam int       PH_IDLE  [4] = '{0, 63, 0, 8};
  localparam int       PH_STALL [4] = '{0, 0, 63, 8};
  localparam logic [5:0] PH_DIV [4] = '{6'd0, 6'd63, 6'd1, 6'd63};
  localparam logic     PH_EN    [4] = '{1'b0, 1'b1, 1'b1, 1'b0};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        beat_typed;
  logic [31:0] beat_rd;

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int beats_sent = 0;
  int errors = 0;

  pin_expect_t pin_bus_q [$];

  // shadow of the management master
  logic [5:0]  div_q = '0;
  logic        en_q = 1'b0;
  logic [4:0]  phy_q = '0;
  logic [4:0]  regad_q = '0;
  logic [1:0]  op_q = '0;
  logic [15:0] wword_q = '0;
  logic [15:0] rword_q = '0;
  logic [63:0] shift_q = '0;
  logic [6:0]  bits_q = '0;
  logic [6:0]  ticks_q = '0;
  logic        mdc_q = 1'b0;
  logic        busy_q = 1'b0;
  logic        st_q = 1'b0;
  logic        ien_q = 1'b0;

  mdm_in_if  in_bus ();
  mdm_out_if out_bus ();

  mdio_master_registers_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic mgmt_ready();
    return en_q && div_q != 6'd0 && !busy_q;
  endfunction

  function automatic logic [5:0] bit_pos();
    return 6'(bits_q - 7'd1);
  endfunction

  task automatic mdio_predict(input mdm_pkg::func_t f, input mdm_pkg::reg_idx_t ri,
                              input logic [31:0] wd, input logic pin,
                              output mdm_pkg::res_t r);
    logic rdy;
    logic rd_op;
    logic drv;
    r = '0;
    rdy = mgmt_ready();
    case (f)
      mdm_pkg::FUNC_READ: begin
        case (ri)
          mdm_pkg::REG_SETUP:   r.read_data = {25'd0, en_q, div_q};
          mdm_pkg::REG_CONTROL: r.read_data = {3'd0, phy_q, 3'd0, regad_q, 8'd0, rdy, 7'd0};
          mdm_pkg::REG_WDATA:   r.read_data = {16'd0, wword_q};
          mdm_pkg::REG_RDATA:   r.read_data = {15'd0, rdy, rword_q};
          mdm_pkg::REG_STATUS:  r.read_data = {31'd0, st_q};
          mdm_pkg::REG_PENDING: r.read_data = {31'd0, st_q & ien_q};
          mdm_pkg::REG_ENABLE:  r.read_data = {31'd0, ien_q};
          default:              r.read_data = '0;
        endcase
      end
      mdm_pkg::FUNC_WRITE: begin
        case (ri)
          mdm_pkg::REG_SETUP: begin
            div_q = wd[5:0];
            en_q  = wd[mdm_pkg::EN_BIT];
          end
          mdm_pkg::REG_CONTROL: begin
            if (!busy_q) begin
              op_q    = wd[15:14];
              regad_q = wd[20:16];
              phy_q   = wd[28:24];
              if (wd[mdm_pkg::INITIATE_BIT] && rdy) begin
                rd_op   = (op_q == mdm_pkg::OP_READ);
                shift_q = {32'hFFFF_FFFF, 2'b01, op_q, phy_q, regad_q,
                           rd_op ? 2'b00 : mdm_pkg::TA_WRITE, rd_op ? 16'h0000 : wword_q};
                bits_q  = 7'd64;
                ticks_q = '0;
                mdc_q   = 1'b0;
                busy_q  = 1'b1;
              end
            end
          end
          mdm_pkg::REG_WDATA:  wword_q = wd[15:0];
          mdm_pkg::REG_STATUS: st_q = wd[0];
          mdm_pkg::REG_ENABLE: ien_q = wd[0];
          mdm_pkg::REG_CLEAR:  st_q = st_q & ~wd[0];
          default: ;
        endcase
      end
      mdm_pkg::FUNC_TICK: begin
        if (busy_q) begin
          if (!en_q || div_q == 6'd0) begin
            busy_q  = 1'b0;
            mdc_q   = 1'b0;
            ticks_q = '0;
            bits_q  = '0;
          end else begin
            ticks_q = ticks_q + 7'd1;
            if (!mdc_q) begin
              if (ticks_q >= {1'b0, div_q} + 7'd1) begin
                mdc_q   = 1'b1;
                ticks_q = '0;
                // read data is sampled on the rising MDC edge
                if (op_q == mdm_pkg::OP_READ && bit_pos() < mdm_pkg::DATA_BITS)
                  shift_q[bit_pos()] = pin;
              end
            end else if (ticks_q >= {1'b0, div_q}) begin
              mdc_q   = 1'b0;
              ticks_q = '0;
              bits_q  = bits_q - 7'd1;
              if (bits_q == 7'd0) begin
                busy_q = 1'b0;
                st_q   = 1'b1;
                if (op_q == mdm_pkg::OP_READ) rword_q = shift_q[15:0];
              end
            end
          end
        end
      end
      default: ;
    endcase
    drv = busy_q && bits_q != 7'd0 &&
          !(op_q == mdm_pkg::OP_READ && bit_pos() < mdm_pkg::RD_RELEASE);
    r.mdc_level  = mdc_q;
    r.mdio_drive = drv;
    r.mdio_out   = drv ? shift_q[bit_pos()] : 1'b0;
    r.irq_line   = st_q & ien_q;
    r.ready_flag = mgmt_ready();
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("%0t: %s got %h want %h", $time, what, got, want);
  endtask

  always @(posedge clk) begin : monitor
    mdm_pkg::res_t r;
    pin_expect_t   e;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        if (pin_bus_q.size() == 0) begin
          report_mismatch("result beat with nothing pending, read_data",
                          out_bus.read_data, '0);
        end else begin
          e = pin_bus_q.pop_front();
          if (out_bus.read_data !== e.pins.read_data)
            report_mismatch("read_data", out_bus.read_data, e.pins.read_data);
          if (e.typed && out_bus.read_data !== e.typed_rd)
            report_mismatch("read_data (table)", out_bus.read_data, e.typed_rd);
          if (out_bus.mdc_level !== e.pins.mdc_level)
            report_mismatch("mdc_level", 32'(out_bus.mdc_level), 32'(e.pins.mdc_level));
          if (out_bus.mdio_out !== e.pins.mdio_out)
            report_mismatch("mdio_out", 32'(out_bus.mdio_out), 32'(e.pins.mdio_out));
          if (out_bus.mdio_drive !== e.pins.mdio_drive)
            report_mismatch("mdio_drive", 32'(out_bus.mdio_drive), 32'(e.pins.mdio_drive));
          if (out_bus.irq_line !== e.pins.irq_line)
            report_mismatch("irq_line", 32'(out_bus.irq_line), 32'(e.pins.irq_line));
          if (out_bus.ready_flag !== e.pins.ready_flag)
            report_mismatch("ready_flag", 32'(out_bus.ready_flag), 32'(e.pins.ready_flag));
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        mdio_predict(mdm_pkg::func_t'(in_bus.func), mdm_pkg::reg_idx_t'(in_bus.reg_index),
                     in_bus.write_data, in_bus.mdio_in, r);
        e.pins     = r;
        e.typed    = beat_typed;
        e.typed_rd = beat_rd;
        pin_bus_q.push_back(e);
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          CFG_DIVIDE_ADDR: div_q = pwdata[5:0];
          CFG_ENABLE_ADDR: en_q = pwdata[0];
          default: ;
        endcase
      end
    end
  end

  initial begin : receiver
    int hold_left;
    int hold_done;
    hold_left = 0;
    hold_done = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else if (hold_done != hold_reqs) begin
        hold_done = hold_reqs;
        hold_left = HOLD_CYCLES - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic push_beat(input mdm_pkg::func_t f, input mdm_pkg::reg_idx_t ri,
                           input logic [31:0] wd, input logic pin, input logic typed,
                           input logic [31:0] rd);
    while ($urandom_range(99) < idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.func       <= f;
    in_bus.reg_index  <= ri;
    in_bus.write_data <= wd;
    in_bus.mdio_in    <= pin;
    beat_typed        <= typed;
    beat_rd           <= rd;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pin_bus_q.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int          p;
    int          k;
    int          n;
    int          target;
    logic [31:0] word;
    in_bus.valid      <= 1'b0;
    in_bus.func       <= mdm_pkg::FUNC_NOP;
    in_bus.reg_index  <= mdm_pkg::REG_SETUP;
    in_bus.write_data <= '0;
    in_bus.mdio_in    <= 1'b0;
    beat_typed        <= 1'b0;
    beat_rd           <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < N_ROWS; k++)
      push_beat(DIRECTED_ROWS[k].f, DIRECTED_ROWS[k].ri, DIRECTED_ROWS[k].wd,
                DIRECTED_ROWS[k].pin, DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].rd);

    for (p = 0; p < 4; p++) begin
      // sender waits for every result before touching the config port
      drain_results();
      apb_write(CFG_DIVIDE_ADDR, {26'd0, PH_DIV[p]});
      apb_write(CFG_ENABLE_ADDR, {31'd0, PH_EN[p]});
      idle_pct = PH_IDLE[p];
      stall_pct <= PH_STALL[p];
      // long receiver hold while beats keep coming
      hold_reqs <= hold_reqs + 1;
      target = beats_sent + PHASE_BEATS;
      while (beats_sent < target) begin
        k = $urandom_range(9);
        if (k < 7) begin
          // full transaction: setup, wdata, control with initiate, then ticks mixed with random reads and writes
          word = $urandom;
          word[mdm_pkg::EN_BIT] = 1'b1;
          word[5:0] = ($urandom_range(3) == 0) ? 6'($urandom_range(2, 3)) : 6'd1;
          push_beat(mdm_pkg::FUNC_WRITE, mdm_pkg::REG_SETUP, word, 1'($urandom_range(1)),
                    1'b0, '0);
          push_beat(mdm_pkg::FUNC_WRITE, mdm_pkg::REG_WDATA, $urandom,
                    1'($urandom_range(1)), 1'b0, '0);
          word = $urandom;
          word[mdm_pkg::INITIATE_BIT] = 1'b1;
          if ($urandom_range(1) == 1) word[15:14] = mdm_pkg::OP_READ;
          push_beat(mdm_pkg::FUNC_WRITE, mdm_pkg::REG_CONTROL, word,
                    1'($urandom_range(1)), 1'b0, '0);
          // a long run of ticks lets a frame at the smallest divider finish
          if ($urandom_range(2) == 0) n = 210;
          else n = $urandom_range(10, 60);
          repeat (n) begin
            case ($urandom_range(49))
              0, 1: push_beat(mdm_pkg::FUNC_READ, mdm_pkg::reg_idx_t'($urandom_range(7)),
                              $urandom, 1'($urandom_range(1)), 1'b0, '0);
              2: push_beat(mdm_pkg::FUNC_WRITE, mdm_pkg::reg_idx_t'($urandom_range(2, 7)),
                           $urandom, 1'($urandom_range(1)), 1'b0, '0);
              default: push_beat(mdm_pkg::FUNC_TICK,
                                 mdm_pkg::reg_idx_t'($urandom_range(7)), $urandom,
                                 1'($urandom_range(1)), 1'b0, '0);
            endcase
          end
        end else if (k == 7) begin
          // drop enable or zero the divider, then tick
          word = $urandom;
          if ($urandom_range(1) == 1) word[mdm_pkg::EN_BIT] = 1'b0;
          else word[5:0] = '0;
          push_beat(mdm_pkg::FUNC_WRITE, mdm_pkg::REG_SETUP, word, 1'($urandom_range(1)),
                    1'b0, '0);
          repeat (3) push_beat(mdm_pkg::FUNC_TICK, mdm_pkg::reg_idx_t'($urandom_range(7)),
                               $urandom, 1'($urandom_range(1)), 1'b0, '0);
        end else begin
          repeat (8) push_beat(mdm_pkg::func_t'($urandom_range(3)),
                               mdm_pkg::reg_idx_t'($urandom_range(7)),
                               $urandom, 1'($urandom_range(1)), 1'b0, '0);
        end
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: files.f
rtl/mdm_pkg.sv
rtl/mdm_in_if.sv
rtl/mdm_out_if.sv
rtl/mdio_master_registers_core.sv
verif/tb_mdio_master_registers_core.sv
